// ===== sv/lfu_pkg.sv =====
package lfu_pkg;

  localparam int OP_W   = 2;
  localparam int ADDR_W = 16;
  localparam int WAY_W  = 2;
  localparam int CNT_W  = 8;

  localparam logic [OP_W-1:0] OP_FIND = 2'd0;
  localparam logic [OP_W-1:0] OP_HIT  = 2'd1;
  localparam logic [OP_W-1:0] OP_INV  = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

  typedef struct packed {
    logic load;
    logic exec;
    logic out_load;
  } lfu_cmd_t;

  typedef struct packed {
    logic is_find;
    logic is_upd;
  } lfu_stat_t;

endpackage

// ===== sv/lfu_ctrl.sv =====
module lfu_ctrl
  import lfu_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  lfu_stat_t stat,
  output lfu_cmd_t  cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic stall;

  assign in_ready     = (state == S_IDLE);
  assign stall        = stat.is_find && out_valid && !out_ready;
  assign cmd.load     = in_valid && in_ready;
  assign cmd.exec     = (state == S_EXEC) && !stall;
  assign cmd.out_load = cmd.exec && stat.is_find;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd.load) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (cmd.exec) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== sv/lfu_dp.sv =====
module lfu_dp
  import lfu_pkg::*;
#(
  parameter int WAYS        = 4,
  parameter int INDEX_BITS  = 4,
  parameter int OFFSET_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  lfu_cmd_t          cmd,
  output lfu_stat_t         stat,
  input  logic [OP_W-1:0]   op,
  input  logic [ADDR_W-1:0] address,
  input  logic [WAY_W-1:0]  way,
  output logic [WAY_W-1:0]  victim_way
);

  localparam int SETS  = 1 << INDEX_BITS;
  localparam int ROW_W = WAYS * CNT_W;
  localparam int LW    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int P     = 1 << LW;

  logic [ROW_W-1:0]      mem [SETS];
  logic [SETS-1:0]       row_vld;
  logic [ROW_W-1:0]      rd_mem;
  logic                  rd_vld;
  logic [OP_W-1:0]       op_q;
  logic [WAY_W-1:0]      way_q;
  logic [INDEX_BITS-1:0] idx_q;
  logic [INDEX_BITS-1:0] idx;
  logic [ROW_W-1:0]      row;
  logic [ROW_W-1:0]      wr_row;
  logic                  wr_en;
  logic [CNT_W-1:0]      lv_cnt [LW+1][P];
  logic [LW-1:0]         lv_idx [LW+1][P];

  assign idx = address[OFFSET_BITS +: INDEX_BITS];
  assign row = rd_vld ? rd_mem : '0;

  assign stat.is_find = (op_q == OP_FIND);
  assign stat.is_upd  = op_q inside {OP_HIT, OP_INV};
  assign wr_en        = cmd.exec && stat.is_upd;

  // saturating hit or clear on the selected way
  always_comb begin
    logic [CNT_W-1:0] c;
    wr_row = row;
    for (int w = 0; w < WAYS; w++) begin
      c = row[w*CNT_W +: CNT_W];
      if (32'(way_q) == w) begin
        if (op_q == OP_INV) begin
          wr_row[w*CNT_W +: CNT_W] = '0;
        end else if (c != CNT_MAX) begin
          wr_row[w*CNT_W +: CNT_W] = c + 1'b1;
        end
      end
    end
  end

  // min tree, ties to the lower way
  always_comb begin
    for (int i = 0; i < P; i++) begin
      lv_idx[0][i] = LW'(i);
      if (i < WAYS) begin
        lv_cnt[0][i] = row[i*CNT_W +: CNT_W];
      end else begin
        lv_cnt[0][i] = CNT_MAX;
      end
    end
    for (int l = 1; l <= LW; l++) begin
      for (int i = 0; i < P; i++) begin
        lv_cnt[l][i] = CNT_MAX;
        lv_idx[l][i] = '0;
        if (i < (P >> l)) begin
          if (lv_cnt[l-1][2*i+1] < lv_cnt[l-1][2*i]) begin
            lv_cnt[l][i] = lv_cnt[l-1][2*i+1];
            lv_idx[l][i] = lv_idx[l-1][2*i+1];
          end else begin
            lv_cnt[l][i] = lv_cnt[l-1][2*i];
            lv_idx[l][i] = lv_idx[l-1][2*i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rd_mem <= mem[idx];
      op_q   <= op;
      way_q  <= way;
      idx_q  <= idx;
    end
    if (wr_en) begin
      mem[idx_q] <= wr_row;
    end
    if (cmd.out_load) begin
      victim_way <= WAY_W'(lv_idx[LW][0]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_vld <= '0;
      rd_vld  <= 1'b0;
    end else begin
      if (cmd.load) rd_vld <= row_vld[idx];
      if (wr_en) row_vld[idx_q] <= 1'b1;
    end
  end

endmodule

// ===== sv/lfu_cache_replacement.sv =====
// lfu_cache_replacement: least-frequently-used victim selection
// input channel (in_valid/in_ready) carries op, address and way; the set is
// address[OFFSET_BITS +: INDEX_BITS]. find returns the way of the set with
// the smallest 8-bit use counter (lowest way on ties); hit increments the
// addressed counter up to 255; invalidate clears it. hit or invalidate with
// a way not below WAYS, and op 3, change nothing.
// only find yields an item on the output channel (out_valid/out_ready,
// victim_way), held in an output register until taken.
// each item is accepted in the idle state, which reads the set row from the
// counter memory; the exec state then runs the min tree or writes the row
// back. a find result is loaded into the output register as exec ends, and
// in_ready stays low through exec, so no new item is taken while one is in
// flight. if the receiver stalls, a further find waits in exec until
// the output register frees; hits and invalidates keep flowing.
// synchronous reset clears the handshake state and marks every set row
// as zero through per-row valid bits, so no clearing pass is needed.
module lfu_cache_replacement
  import lfu_pkg::*;
#(
  parameter int WAYS        = 4,
  parameter int INDEX_BITS  = 4,
  parameter int OFFSET_BITS = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [OP_W-1:0]   op,
  input  logic [ADDR_W-1:0] address,
  input  logic [WAY_W-1:0]  way,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WAY_W-1:0]  victim_way
);

  lfu_cmd_t  cmd;
  lfu_stat_t stat;

  lfu_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  lfu_dp #(
    .WAYS        (WAYS),
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .op         (op),
    .address    (address),
    .way        (way),
    .victim_way (victim_way)
  );

endmodule

// ===== sv/lfu_chk.sv =====
module lfu_chk
  import lfu_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic [OP_W-1:0]   op,
  input logic [ADDR_W-1:0] address,
  input logic [WAY_W-1:0]  way,
  input logic              out_valid,
  input logic              out_ready,
  input logic [WAY_W-1:0]  victim_way
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(victim_way))
    else $error("result dropped or changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item accepted while one is in flight");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result present after reset");

  a_result_from_find: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready && (op == OP_FIND), 2))
    else $error("result without a find two cycles earlier");

endmodule

bind lfu_cache_replacement lfu_chk u_chk (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import lfu_pkg::*;

  localparam int WAYS        = 4;
  localparam int INDEX_BITS  = 4;
  localparam int OFFSET_BITS = 4;
  localparam int SETS        = 1 << INDEX_BITS;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;

  logic              clk;
  logic              rst        = 1'b1;
  logic              in_valid   = 1'b0;
  logic              in_ready;
  logic [OP_W-1:0]   op         = OP_FIND;
  logic [ADDR_W-1:0] address    = '0;
  logic [WAY_W-1:0]  way        = '0;
  logic              out_valid;
  logic              out_ready  = 1'b0;
  logic [WAY_W-1:0]  victim_way;

  lfu_cache_replacement #(
    .WAYS        (WAYS),
    .INDEX_BITS  (INDEX_BITS),
    .OFFSET_BITS (OFFSET_BITS)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .address    (address),
    .way        (way),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .victim_way (victim_way)
  );

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] addr;
    logic [WAY_W-1:0]  way;
    logic              typed;
    logic [WAY_W-1:0]  victim;
  } dir_row_t;

  logic [CNT_W-1:0] use_cnt [SETS][WAYS];
  logic [WAY_W-1:0] victim_q [$];

  int idle_pct  = 0;
  int stall_pct = 0;
  int mismatch_cnt = 0;
  int n_find = 0, n_hit = 0, n_inv = 0, n_none = 0, n_sat = 0, n_checked = 0;

  dir_row_t dir_tab [22];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [WAY_W-1:0] least_used_way(input logic [ADDR_W-1:0] a);
    int s;
    int best;
    s = int'(a[OFFSET_BITS +: INDEX_BITS]);
    best = 0;
    for (int w = 1; w < WAYS; w++) begin
      if (use_cnt[s][w] < use_cnt[s][best]) best = w;
    end
    return WAY_W'(best);
  endfunction

  task automatic send_item(input logic [OP_W-1:0] o, input logic [ADDR_W-1:0] a,
                           input logic [WAY_W-1:0] w, input logic typed,
                           input logic [WAY_W-1:0] typed_victim);
    int s;
    while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    op       <= o;
    address  <= a;
    way      <= w;
    do @(posedge clk); while (!in_ready);
    s = int'(a[OFFSET_BITS +: INDEX_BITS]);
    case (o)
      OP_FIND: begin
        victim_q.push_back(typed ? typed_victim : least_used_way(a));
        n_find++;
      end
      OP_HIT: begin
        if (use_cnt[s][w] != CNT_MAX) use_cnt[s][w] = use_cnt[s][w] + 1'b1;
        else n_sat++;
        n_hit++;
      end
      OP_INV: begin
        use_cnt[s][w] = '0;
        n_inv++;
      end
      default: n_none++;
    endcase
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (victim_q.size() != 0) @(posedge clk);
  endtask

  // receiver side
  initial begin
    logic [WAY_W-1:0] want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        if (victim_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("unexpected item: victim_way=%0d", victim_way);
        end else begin
          want = victim_q.pop_front();
          n_checked++;
          if (victim_way !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("victim_way mismatch: expected %0d got %0d", want, victim_way);
          end
        end
      end
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #5ms;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int r;
    int wait_cnt;
    logic [ADDR_W-1:0] a;
    logic [OP_W-1:0] o;

    for (int s = 0; s < SETS; s++)
      for (int w = 0; w < WAYS; w++) use_cnt[s][w] = '0;

    dir_tab = '{
      '{OP_FIND, 16'h0000, 2'd0, 1'b1, 2'd0},
      '{OP_FIND, 16'hFFFF, 2'd3, 1'b1, 2'd0},
      '{OP_HIT,  16'h0003, 2'd0, 1'b0, 2'd0},
      '{OP_FIND, 16'h000F, 2'd0, 1'b1, 2'd1},
      '{OP_HIT,  16'h0008, 2'd1, 1'b0, 2'd0},
      '{OP_HIT,  16'hFF00, 2'd2, 1'b0, 2'd0},
      '{OP_HIT,  16'h0A05, 2'd3, 1'b0, 2'd0},
      '{OP_FIND, 16'h0000, 2'd3, 1'b1, 2'd0},
      '{OP_INV,  16'h0001, 2'd2, 1'b0, 2'd0},
      '{OP_FIND, 16'h0000, 2'd0, 1'b1, 2'd2},
      '{OP_NONE, 16'h0000, 2'd2, 1'b0, 2'd0},
      '{OP_FIND, 16'h0000, 2'd1, 1'b1, 2'd2},
      '{OP_HIT,  16'hFFF0, 2'd0, 1'b0, 2'd0},
      '{OP_HIT,  16'hFFF0, 2'd0, 1'b0, 2'd0},
      '{OP_HIT,  16'hFFFF, 2'd1, 1'b0, 2'd0},
      '{OP_FIND, 16'hFFF5, 2'd0, 1'b1, 2'd2},
      '{OP_INV,  16'hFFF0, 2'd0, 1'b0, 2'd0},
      '{OP_FIND, 16'hFFF0, 2'd2, 1'b1, 2'd0},
      '{OP_HIT,  16'h0010, 2'd3, 1'b0, 2'd0},
      '{OP_FIND, 16'h001F, 2'd0, 1'b0, 2'd0},
      '{OP_FIND, 16'h8070, 2'd1, 1'b0, 2'd0},
      '{OP_NONE, 16'hFFFF, 2'd3, 1'b0, 2'd0}
    };

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_tab[i])
      send_item(dir_tab[i].op, dir_tab[i].addr, dir_tab[i].way,
                dir_tab[i].typed, dir_tab[i].victim);

    // drive every way of set 9 into saturation, then ties at the ceiling
    for (int w = 0; w < WAYS; w++)
      for (int k = 0; k < 260; k++)
        send_item(OP_HIT, {8'($urandom_range(255)), 4'd9, 4'($urandom_range(15))},
                  WAY_W'(w), 1'b0, '0);
    send_item(OP_FIND, 16'h0090, 2'd2, 1'b1, 2'd0);
    send_item(OP_INV,  16'hFF9F, 2'd2, 1'b0, '0);
    send_item(OP_FIND, 16'h0095, 2'd0, 1'b1, 2'd2);
    send_item(OP_HIT,  16'h0090, 2'd2, 1'b0, '0);
    send_item(OP_FIND, 16'h1290, 2'd3, 1'b0, '0);
    drain_results();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        default: begin idle_pct = 19; stall_pct = 19; end
      endcase
      for (int i = 0; i < 96; i++) begin
        r = $urandom_range(99);
        if (r < 35) o = OP_FIND;
        else if (r < 75) o = OP_HIT;
        else if (r < 90) o = OP_INV;
        else o = OP_NONE;
        a = ADDR_W'($urandom());
        // concentrate on a few sets so counters climb and minima move around
        if ($urandom_range(99) < 70)
          a[OFFSET_BITS +: INDEX_BITS] = INDEX_BITS'($urandom_range(2, 4));
        send_item(o, a, WAY_W'($urandom_range(3)), 1'b0, '0);
      end
      drain_results();
    end

    idle_pct  = 0;
    stall_pct = 0;
    in_valid <= 1'b0;
    wait_cnt = 0;
    while (victim_q.size() != 0 && wait_cnt < 10000) begin
      @(posedge clk);
      wait_cnt++;
    end
    if (victim_q.size() != 0) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      $display("covered %0d finds (%0d checked), %0d hits (%0d at ceiling), %0d invalidates,",
               n_find, n_checked, n_hit, n_sat, n_inv);
      $display("%0d undefined ops, over four idle/stall mixes; mismatches %0d",
               n_none, mismatch_cnt);
      if (mismatch_cnt == 0 && victim_q.size() == 0) begin
        $display("PASSED: all results match");
      end else begin
        $display("FAILED: results differ");
      end
      $finish;
    end
  end

endmodule
